// File: rtl/nrmac_pkg.sv
// Shared types and constants for the NR MAC subPDU assembler.
// Depends on nothing; nrmac_regs, nrmac_core, nrmac_emit and the top level import it.
`default_nettype none

package nrmac_pkg;

  localparam int unsigned SpaceW = 18;
  localparam int unsigned LenW   = 16;
  localparam int unsigned LcidW  = 6;
  localparam int unsigned ByteW  = 8;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_SUBPDU  = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_PACK    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_UNEXPECTED = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_e;

  typedef enum logic {
    REG_IS_UPLINK  = 1'b0,
    REG_PDU_LENGTH = 1'b1
  } reg_idx_e;

  localparam logic [LcidW-1:0] LcidCcch64 = 6'd0;
  localparam logic [LcidW-1:0] LcidCcch48 = 6'd52;
  localparam logic [LcidW-1:0] LcidConRes = 6'd62;
  localparam logic [LcidW-1:0] LcidPad    = 6'h3f;

  localparam logic [LenW-1:0] Ccch48Body = 16'd6;
  localparam logic [LenW-1:0] Ccch64Body = 16'd8;
  localparam logic [LenW-1:0] ConResBody = 16'd6;

  typedef struct packed {
    logic              is_uplink;
    logic [SpaceW-1:0] pdu_length;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0]  byte0;
    logic [ByteW-1:0]  byte1;
    logic [ByteW-1:0]  byte2;
    logic [1:0]        last_idx;
    logic              byte_valid;
    logic [SpaceW-1:0] fill_zeros;
    status_e           status;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/nrmac_if.sv
// Valid/ready channel interfaces for the request and the PDU byte stream.
// Field widths follow the assembler's item formats.
`default_nettype none

interface nrmac_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [5:0]  lcid;
  logic [15:0] body_len;
  logic [7:0]  data_byte;

  modport source (output valid, kind, lcid, body_len, data_byte, input ready);
  modport sink (input valid, kind, lcid, body_len, data_byte, output ready);
endinterface

interface nrmac_pdu_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic [17:0] fill_zeros;
  logic        last;
  logic [1:0]  status;

  modport source (output valid, out_byte, byte_valid, fill_zeros, last, status,
                  input ready);
  modport sink (input valid, out_byte, byte_valid, fill_zeros, last, status,
                output ready);
endinterface

`default_nettype wire

// File: rtl/nrmac_regs.sv
// APB configuration registers of the assembler: uplink select and PDU length.
// Depends on nrmac_pkg.
`default_nettype none

module nrmac_regs
  import nrmac_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_IS_UPLINK:  cfg_d.is_uplink  = pwdata[0];
        REG_PDU_LENGTH: cfg_d.pdu_length = pwdata[SpaceW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_IS_UPLINK:  prdata = {31'd0, cfg_q.is_uplink};
      REG_PDU_LENGTH: prdata = {{(32-SpaceW){1'b0}}, cfg_q.pdu_length};
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

endmodule

`default_nettype wire

// File: rtl/nrmac_core.sv
// Request register, PDU space and body tracking, and subheader formation.
// Depends on nrmac_pkg and nrmac_req_if; feeds nrmac_emit with one bundle per request.
`default_nettype none

module nrmac_core
  import nrmac_pkg::*;
#(
  parameter int unsigned LONG_LENGTH_THRESHOLD = 256
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  cfg_t       cfg_i,
  nrmac_req_if.sink  req,
  input  wire logic  free_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  logic              inq_v_q, inq_v_d;
  kind_e             kind_q;
  logic [LcidW-1:0]  lcid_q;
  logic [LenW-1:0]   len_q;
  logic [ByteW-1:0]  data_q;
  logic [SpaceW-1:0] space_q, space_d;
  logic [LenW-1:0]   owed_q, owed_d;
  logic              take, adv;

  logic              is_ccch, is_conres, is_long;
  logic [LcidW-1:0]  code;
  logic [LenW-1:0]   body;
  logic [SpaceW-1:0] need, len_p1, body_p1;
  logic              fits;
  res_t              res;

  assign adv       = inq_v_q && free_i;
  assign req.ready = !inq_v_q || free_i;
  assign take      = req.valid && req.ready;
  assign inq_v_d   = take ? 1'b1 : (adv ? 1'b0 : inq_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_v_q <= 1'b0;
      space_q <= '0;
      owed_q  <= '0;
    end else begin
      inq_v_q <= inq_v_d;
      space_q <= space_d;
      owed_q  <= owed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q <= kind_e'(req.kind);
      lcid_q <= req.lcid;
      len_q  <= req.body_len;
      data_q <= req.data_byte;
    end
  end

  always_comb begin
    is_ccch   = cfg_i.is_uplink && (lcid_q == LcidCcch64 || lcid_q == LcidCcch48);
    is_conres = !cfg_i.is_uplink && (lcid_q == LcidConRes);
    is_long   = ({1'b0, len_q} >= (LenW+1)'(LONG_LENGTH_THRESHOLD));
    code      = lcid_q;
    if (is_ccch && lcid_q == LcidCcch64 && len_q == Ccch48Body) begin
      code = LcidCcch48;
    end
    if (is_ccch) begin
      body = (code == LcidCcch48) ? Ccch48Body : Ccch64Body;
    end else if (is_conres) begin
      body = ConResBody;
    end else begin
      body = len_q;
    end
    len_p1  = SpaceW'(len_q) + SpaceW'(1);
    body_p1 = SpaceW'(body) + SpaceW'(1);
    if (is_ccch || is_conres) begin
      need = body_p1;
    end else begin
      need = SpaceW'(body) + (is_long ? SpaceW'(3) : SpaceW'(2));
    end
    fits = (need <= space_q) && (!is_ccch || len_p1 <= space_q);
  end

  always_comb begin
    res       = '0;
    res.status = ST_OK;
    space_d   = space_q;
    owed_d    = owed_q;
    if (adv) begin
      case (kind_q)
        KIND_START: begin
          res.status = (owed_q != '0) ? ST_INCOMPLETE : ST_OK;
          space_d    = cfg_i.pdu_length;
          owed_d     = '0;
        end
        KIND_PAYLOAD: begin
          if (owed_q == '0) begin
            res.status = ST_UNEXPECTED;
          end else begin
            owed_d         = owed_q - LenW'(1);
            res.byte0      = data_q;
            res.byte_valid = 1'b1;
          end
        end
        default: begin
          if (owed_q != '0) begin
            res.status = ST_INCOMPLETE;
          end else if (kind_q == KIND_PACK) begin
            if (space_q != '0) begin
              res.byte0      = {2'b00, LcidPad};
              res.byte_valid = 1'b1;
              res.fill_zeros = space_q - SpaceW'(1);
              space_d        = '0;
            end
          end else if (!fits) begin
            res.status = ST_NO_SPACE;
          end else begin
            space_d        = space_q - need;
            owed_d         = body;
            res.byte_valid = 1'b1;
            if (is_ccch || is_conres) begin
              res.byte0 = {2'b00, code};
            end else if (is_long) begin
              res.byte0    = {2'b01, code};
              res.byte1    = body[15:8];
              res.byte2    = body[7:0];
              res.last_idx = 2'd2;
            end else begin
              res.byte0    = {2'b00, code};
              res.byte1    = body[7:0];
              res.last_idx = 2'd1;
            end
          end
        end
      endcase
    end
  end

  assign res_valid_o = adv;
  assign res_o       = res;

endmodule

`default_nettype wire

// File: rtl/nrmac_emit.sv
// Result register that plays out the one to three results formed for a request.
// Depends on nrmac_pkg and nrmac_pdu_if.
`default_nettype none

module nrmac_emit
  import nrmac_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   res_valid_i,
  input  res_t        res_i,
  output logic        free_o,
  nrmac_pdu_if.source pdu
);

  logic       v_q, v_d;
  logic [1:0] idx_q, idx_d;
  res_t       res_q;
  logic       at_last, fire;

  assign at_last = (idx_q == res_q.last_idx);
  assign fire    = v_q && pdu.ready;
  assign free_o  = !v_q || (pdu.ready && at_last);

  always_comb begin
    v_d   = v_q;
    idx_d = idx_q;
    if (res_valid_i) begin
      v_d   = 1'b1;
      idx_d = 2'd0;
    end else if (fire) begin
      if (at_last) begin
        v_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      idx_q <= '0;
    end else begin
      v_q   <= v_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  always_comb begin
    case (idx_q)
      2'd1:    pdu.out_byte = res_q.byte1;
      2'd2:    pdu.out_byte = res_q.byte2;
      default: pdu.out_byte = res_q.byte0;
    endcase
  end

  assign pdu.valid      = v_q;
  assign pdu.byte_valid = res_q.byte_valid;
  assign pdu.fill_zeros = res_q.fill_zeros;
  assign pdu.status     = res_q.status;
  assign pdu.last       = at_last;

endmodule

`default_nettype wire

// File: rtl/nr_mac_subpdu_assembler.sv
// Top level of the NR MAC subPDU assembler: registers, request stage and byte output.
// Depends on nrmac_pkg, nrmac_if, nrmac_regs, nrmac_core and nrmac_emit.
//
// Channel   Direction  Transaction
// req_i     in         start, subPDU header request, payload byte or pack
// pdu_o     out        one PDU byte or status result, last marks the request end
// APB       in/out     writes is_uplink (0x0) and pdu_length (0x4)
//
// A request is held in the request register and then yields one to three results,
// played out one per cycle from the result register while pdu_o is ready.
// Single-result requests sustain one per cycle while pdu_o is ready; a 2- or 3-byte subheader
// holds the request stage until its last byte is taken. A stall on pdu_o holds the result
// register and the request register behind it. Reset clears the space and body counters.
`default_nettype none

module nr_mac_subpdu_assembler
  import nrmac_pkg::*;
#(
  parameter int unsigned LONG_LENGTH_THRESHOLD = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  nrmac_req_if.sink        req_i,
  nrmac_pdu_if.source      pdu_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t cfg;
  res_t res;
  logic res_valid;
  logic free;

  nrmac_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nrmac_core #(
    .LONG_LENGTH_THRESHOLD (LONG_LENGTH_THRESHOLD)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req         (req_i),
    .free_i      (free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  nrmac_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (free),
    .pdu         (pdu_o)
  );

endmodule

`default_nettype wire

// File: tb/nrmac_pdu_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the NR MAC subPDU assembler: it mirrors the APB register writes,
// predicts the PDU byte stream of every accepted request and compares each result.
// Depends on nrmac_pkg and the channel interfaces of nrmac_if.
module nrmac_pdu_checker
  import nrmac_pkg::*;
#(
  parameter int unsigned LONG_LENGTH_THRESHOLD = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  nrmac_req_if            req_i,
  nrmac_pdu_if            pdu_i,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic            pready,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output int unsigned     fail_count_o,
  output int unsigned     pending_o,
  output int unsigned     checked_o,
  output logic [LenW-1:0] body_owed_o
);

  typedef struct packed {
    logic [ByteW-1:0]  out_byte;
    logic              byte_valid;
    logic [SpaceW-1:0] fill_zeros;
    logic              last;
    status_e           status;
  } pdu_beat_t;

  pdu_beat_t         pdu_expected_q[$];
  logic              cfg_uplink;
  logic [SpaceW-1:0] cfg_pdu_length;
  logic [SpaceW-1:0] space_left;
  logic [LenW-1:0]   body_owed;
  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       checked;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign checked_o    = checked;
  assign body_owed_o  = body_owed;

  function automatic pdu_beat_t make_beat(input logic [ByteW-1:0] data,
                                          input logic valid,
                                          input logic [SpaceW-1:0] fill,
                                          input status_e status);
    pdu_beat_t beat;
    beat.out_byte   = data;
    beat.byte_valid = valid;
    beat.fill_zeros = fill;
    beat.last       = 1'b0;
    beat.status     = status;
    return beat;
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  task automatic predict_request(input kind_e kind, input logic [LcidW-1:0] lcid,
                                 input logic [LenW-1:0] sdu_len,
                                 input logic [ByteW-1:0] data);
    pdu_beat_t        beats[3];
    int unsigned      n, hdr, body, len32, i;
    logic [LcidW-1:0] code;
    logic             fbit, fits;
    n        = 1;
    hdr      = 0;
    body     = 0;
    len32    = 32'(sdu_len);
    code     = lcid;
    fbit     = 1'b0;
    fits     = 1'b0;
    beats[0] = make_beat('0, 1'b0, '0, ST_OK);
    beats[1] = beats[0];
    beats[2] = beats[0];
    if (kind == KIND_START) begin
      beats[0].status = (body_owed != 0) ? ST_INCOMPLETE : ST_OK;
      space_left = cfg_pdu_length;
      body_owed  = '0;
    end else if (kind == KIND_PAYLOAD) begin
      if (body_owed == 0) begin
        beats[0].status = ST_UNEXPECTED;
      end else begin
        body_owed--;
        beats[0] = make_beat(data, 1'b1, '0, ST_OK);
      end
    end else if (body_owed != 0) begin
      beats[0].status = ST_INCOMPLETE;
    end else if (kind == KIND_PACK) begin
      if (space_left != 0) begin
        beats[0] = make_beat({2'b00, LcidPad}, 1'b1, space_left - 1'b1, ST_OK);
        space_left = '0;
      end
    end else begin
      if (cfg_uplink && (lcid == LcidCcch64 || lcid == LcidCcch48)) begin
        code = (lcid == LcidCcch64 && sdu_len == Ccch48Body) ? LcidCcch48 : lcid;
        body = (code == LcidCcch48) ? 32'(Ccch48Body) : 32'(Ccch64Body);
        hdr  = 1;
        fits = (1 + len32 <= space_left) && (1 + body <= space_left);
      end else if (!cfg_uplink && lcid == LcidConRes) begin
        body = 32'(ConResBody);
        hdr  = 1;
        fits = (1 + body <= space_left);
      end else begin
        body = len32;
        if (len32 >= LONG_LENGTH_THRESHOLD) begin
          hdr  = 3;
          fbit = 1'b1;
        end else begin
          hdr = 2;
        end
        fits = (hdr + body <= space_left);
      end
      if (!fits) begin
        beats[0].status = ST_NO_SPACE;
      end else begin
        space_left = space_left - SpaceW'(hdr + body);
        body_owed  = LenW'(body);
        beats[0]   = make_beat({1'b0, fbit, code}, 1'b1, '0, ST_OK);
        if (hdr == 3) begin
          beats[1] = make_beat(body[15:8], 1'b1, '0, ST_OK);
          beats[2] = make_beat(body[7:0], 1'b1, '0, ST_OK);
        end else if (hdr == 2) begin
          beats[1] = make_beat(body[7:0], 1'b1, '0, ST_OK);
        end
        n = hdr;
      end
    end
    beats[n-1].last = 1'b1;
    for (i = 0; i < n; i++) pdu_expected_q.push_back(beats[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pdu_beat_t exp_beat;
    if (!rst_ni) begin
      pdu_expected_q.delete();
      cfg_uplink     = 1'b0;
      cfg_pdu_length = '0;
      space_left     = '0;
      body_owed      = '0;
      fail_count     = 0;
      pending        = 0;
      checked        = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[2]))
          REG_IS_UPLINK:  cfg_uplink = pwdata[0];
          REG_PDU_LENGTH: cfg_pdu_length = pwdata[SpaceW-1:0];
          default: ;
        endcase
      end
      if (pdu_i.valid && pdu_i.ready) begin
        checked++;
        if (pdu_expected_q.size() == 0) begin
          report_failure($sformatf(
              "unexpected result at %0t: byte %02h valid %0b fill %0d last %0b status %0d",
              $time, pdu_i.out_byte, pdu_i.byte_valid, pdu_i.fill_zeros, pdu_i.last,
              pdu_i.status));
        end else begin
          exp_beat = pdu_expected_q.pop_front();
          if (pdu_i.out_byte !== exp_beat.out_byte || pdu_i.byte_valid !== exp_beat.byte_valid
              || pdu_i.fill_zeros !== exp_beat.fill_zeros || pdu_i.last !== exp_beat.last
              || pdu_i.status !== exp_beat.status) begin
            report_failure($sformatf(
                {"mismatch at %0t: expected byte %02h valid %0b fill %0d last %0b status %0d,",
                 " got byte %02h valid %0b fill %0d last %0b status %0d"},
                $time, exp_beat.out_byte, exp_beat.byte_valid, exp_beat.fill_zeros,
                exp_beat.last, exp_beat.status, pdu_i.out_byte, pdu_i.byte_valid,
                pdu_i.fill_zeros, pdu_i.last, pdu_i.status));
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        predict_request(kind_e'(req_i.kind), req_i.lcid, req_i.body_len, req_i.data_byte);
      end
      pending = pdu_expected_q.size();
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Top of the assembler testbench: clock, reset, APB register setup, request stimulus
// and output backpressure. Results are checked by nrmac_pdu_checker.
module tb;
  import nrmac_pkg::*;

  localparam int unsigned LongThreshold = 256;
  localparam int unsigned RandomItems   = 75;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            psel;
  logic            penable;
  logic            pwrite;
  logic            pready;
  logic [2:0]      paddr;
  logic [31:0]     pwdata;
  logic [31:0]     prdata;
  int unsigned     fail_count;
  int unsigned     pending;
  int unsigned     checked;
  logic [LenW-1:0] body_owed;
  int unsigned     items_sent;
  int unsigned     configs_written;
  int unsigned     sender_calm;
  int unsigned     receiver_calm;
  int unsigned     stall_left;

  nrmac_req_if req_if ();
  nrmac_pdu_if pdu_if ();

  nr_mac_subpdu_assembler #(
    .LONG_LENGTH_THRESHOLD(LongThreshold)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .pdu_o  (pdu_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  nrmac_pdu_checker #(
    .LONG_LENGTH_THRESHOLD(LongThreshold)
  ) chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_if),
    .pdu_i       (pdu_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .body_owed_o (body_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic int unsigned sender_gap();
    if (sender_calm > 0) begin
      sender_calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      sender_calm = $urandom_range(15, 40);
      return 0;
    end
    if ($urandom_range(0, 1) == 0) return 0;
    return idle_length();
  endfunction

  task automatic send_item(input kind_e kind, input logic [LcidW-1:0] lcid,
                           input logic [LenW-1:0] sdu_len, input logic [ByteW-1:0] data);
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.kind      <= kind;
    req_if.lcid      <= lcid;
    req_if.body_len  <= sdu_len;
    req_if.data_byte <= data;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic uplink, input logic [SpaceW-1:0] pdu_len);
    wait_for_results();
    apb_write(REG_IS_UPLINK, {31'd0, uplink});
    apb_write(REG_PDU_LENGTH, {14'd0, pdu_len});
    configs_written++;
  endtask

  initial begin : backpressure
    pdu_if.ready  = 1'b0;
    stall_left    = 0;
    receiver_calm = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (receiver_calm > 0) begin
        receiver_calm--;
        pdu_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        pdu_if.ready <= 1'b0;
      end else if ($urandom_range(0, 59) == 0) begin
        receiver_calm = $urandom_range(20, 60);
        pdu_if.ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = idle_length() - 1;
        pdu_if.ready <= 1'b0;
      end else begin
        pdu_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int unsigned       r, n_sub, owed, n_bytes, random_start, j, k;
    logic [LcidW-1:0]  lcid;
    logic [LenW-1:0]   sdu_len;
    logic [SpaceW-1:0] plen;
    logic              uplink;
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_if.valid     = 1'b0;
    req_if.kind      = KIND_START;
    req_if.lcid      = '0;
    req_if.body_len  = '0;
    req_if.data_byte = '0;
    items_sent       = 0;
    configs_written  = 0;
    sender_calm      = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: nothing fits before the first start.
    send_item(KIND_SUBPDU, 6'd63, 16'hffff, 8'h00);
    send_item(KIND_PAYLOAD, 6'd0, 16'd0, 8'hff);
    send_item(KIND_PACK, 6'd0, 16'd0, 8'h00);
    send_item(KIND_START, 6'd0, 16'd0, 8'h00);

    // Uplink CCCH forms, requests during a body and an abandoned body.
    set_config(1'b1, 18'd20);
    send_item(KIND_START, 6'd0, 16'd0, 8'h00);
    send_item(KIND_SUBPDU, LcidCcch64, 16'd6, 8'h00);
    send_item(KIND_PAYLOAD, 6'd0, 16'd0, 8'h00);
    send_item(KIND_PAYLOAD, 6'd0, 16'd0, 8'hff);
    send_item(KIND_PAYLOAD, 6'd0, 16'd0, 8'h5a);
    send_item(KIND_PAYLOAD, 6'd0, 16'd0, 8'ha5);
    send_item(KIND_PAYLOAD, 6'd0, 16'd0, 8'h01);
    send_item(KIND_PAYLOAD, 6'd0, 16'd0, 8'h80);
    send_item(KIND_SUBPDU, LcidCcch64, 16'd8, 8'h00);
    send_item(KIND_SUBPDU, 6'd1, 16'd1, 8'h00);
    send_item(KIND_PAYLOAD, 6'd0, 16'd0, 8'h12);
    send_item(KIND_START, 6'd0, 16'd0, 8'h00);
    send_item(KIND_SUBPDU, LcidCcch64, 16'd25, 8'h00);
    send_item(KIND_SUBPDU, 6'd33, 16'd0, 8'h00);
    send_item(KIND_PACK, 6'd0, 16'd0, 8'h00);

    // Downlink at the largest PDU: contention resolution and long length fields.
    set_config(1'b0, 18'h3ffff);
    send_item(KIND_START, 6'd0, 16'd0, 8'h00);
    send_item(KIND_SUBPDU, LcidConRes, 16'd0, 8'h00);
    send_item(KIND_PACK, 6'd0, 16'd0, 8'h00);
    send_item(KIND_START, 6'd0, 16'd0, 8'h00);
    send_item(KIND_SUBPDU, 6'd20, 16'hffff, 8'h00);
    send_item(KIND_START, 6'd0, 16'd0, 8'h00);
    send_item(KIND_SUBPDU, 6'd8, 16'd256, 8'h00);
    send_item(KIND_START, 6'd0, 16'd0, 8'h00);
    send_item(KIND_PACK, 6'd0, 16'd0, 8'h00);

    random_start = items_sent;
    while (items_sent - random_start < RandomItems) begin
      uplink = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 60) plen = SpaceW'($urandom_range(0, 60));
      else if (r < 80) plen = SpaceW'($urandom_range(61, 600));
      else if (r < 92) plen = SpaceW'($urandom_range(0, 18'h3ffff));
      else if (r < 96) plen = '0;
      else plen = 18'h3ffff;
      set_config(uplink, plen);
      send_item(KIND_START, 6'($urandom), 16'($urandom), 8'($urandom));
      n_sub = $urandom_range(1, 4);
      for (j = 0; j < n_sub; j++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(kind_e'($urandom_range(0, 3)), 6'($urandom), 16'($urandom), 8'($urandom));
        end
        r = $urandom_range(0, 99);
        if (r < 35) begin
          case ($urandom_range(0, 3))
            0: lcid = LcidCcch64;
            1: lcid = LcidCcch48;
            2: lcid = LcidConRes;
            default: lcid = LcidPad;
          endcase
        end else begin
          lcid = LcidW'($urandom_range(0, 63));
        end
        r = $urandom_range(0, 99);
        if (r < 60) sdu_len = LenW'($urandom_range(0, 12));
        else if (r < 70) sdu_len = ($urandom_range(0, 1) == 0) ? 16'd6 : 16'd8;
        else if (r < 80) sdu_len = LenW'($urandom_range(250, 300));
        else if (r < 90) sdu_len = LenW'($urandom_range(0, 16'hffff));
        else sdu_len = LenW'($urandom_range(13, 40));
        send_item(KIND_SUBPDU, lcid, sdu_len, 8'($urandom));
        owed = 32'(body_owed);
        r = $urandom_range(0, 99);
        if (owed > 24) n_bytes = $urandom_range(0, 3);
        else if (r < 85) n_bytes = owed;
        else if (r < 93) n_bytes = (owed > 0) ? $urandom_range(0, owed - 1) : 0;
        else n_bytes = owed + 1;
        for (k = 0; k < n_bytes; k++) begin
          send_item(KIND_PAYLOAD, 6'($urandom), 16'($urandom), 8'($urandom));
        end
      end
      r = $urandom_range(0, 99);
      if (r < 85) send_item(KIND_PACK, 6'($urandom), 16'($urandom), 8'($urandom));
      if (r >= 75 && r < 85) send_item(KIND_PACK, 6'($urandom), 16'($urandom), 8'($urandom));
    end

    wait_for_results();
    repeat (20) @(negedge clk);
    $display("Sent %0d requests under %0d register settings; %0d results checked.",
             items_sent, configs_written, checked);
    $display("Failures: %0d, results still outstanding: %0d.", fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
